>>> src/bdq_pkg.sv
// shared constants, codes and controller/datapath command types for the
// bounded indexed deque; no dependencies
`default_nettype none

package bdq_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_AT    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_INSERT_AT  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic latch_req;
        logic exec;
        logic capture_rd;
        logic shift_rd;
        logic shift_wr;
        logic place;
        logic load_out;
    } bdq_cmd_t;

    typedef struct packed {
        logic needs_read;
        logic needs_shift;
        logic shift_last;
    } bdq_stat_t;

endpackage

`default_nettype wire

>>> src/bdq_req_if.sv
// request channel: valid/ready handshake with mode, value and position
// depends on bdq_pkg
`default_nettype none

interface bdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [bdq_pkg::MODE_W-1:0]          mode;
    logic signed [bdq_pkg::DATA_W-1:0]   item_value;
    logic [bdq_pkg::POS_W-1:0]           position;

    modport source (output valid, output mode, output item_value, output position,
                    input ready);
    modport sink   (input valid, input mode, input item_value, input position,
                    output ready);
endinterface

`default_nettype wire

>>> src/bdq_rsp_if.sv
// result channel: valid/ready handshake with value, status and count
// depends on bdq_pkg
`default_nettype none

interface bdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [bdq_pkg::DATA_W-1:0]   result_value;
    logic [bdq_pkg::STATUS_W-1:0]        status;
    logic [bdq_pkg::COUNT_W-1:0]         entry_count;

    modport source (output valid, output result_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input result_value, input status, input entry_count,
                     output ready);
endinterface

`default_nettype wire

>>> src/bdq_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/bdq_ctrl.sv
// sequencing state machine for the deque: handshakes and datapath commands
// depends on bdq_pkg
`default_nettype none

module bdq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    input  wire bdq_pkg::bdq_stat_t  stat,
    output bdq_pkg::bdq_cmd_t        cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT_RD,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.needs_read)
                begin
                    state_next = S_WAIT_RD;
                end
                else if (stat.needs_shift)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_WAIT_RD:
            begin
                cmd.capture_rd = 1'b1;
                state_next     = S_FINISH;
            end
            S_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = stat.shift_last ? S_PLACE : S_SHIFT_RD;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> src/bdq_dpath.sv
// deque datapath: request registers, ring pointers, entry ram and result registers
// depends on bdq_pkg and bdq_ram
`default_nettype none

module bdq_dpath #(
    parameter int CAPACITY    = bdq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire bdq_pkg::bdq_cmd_t                   cmd,
    output bdq_pkg::bdq_stat_t                       stat,
    input  wire logic [bdq_pkg::MODE_W-1:0]          mode,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]   item_value,
    input  wire logic [bdq_pkg::POS_W-1:0]           position,
    output logic signed [bdq_pkg::DATA_W-1:0]        result_value,
    output logic [bdq_pkg::STATUS_W-1:0]             status,
    output logic [bdq_pkg::COUNT_W-1:0]              entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W) + 1;

    logic [bdq_pkg::MODE_W-1:0]   mode_reg;
    logic [VALUE_WIDTH-1:0]       val_reg;
    logic [bdq_pkg::POS_W-1:0]    pos_reg;
    logic [AW-1:0]                front_reg;
    logic [AW-1:0]                front_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                k_reg;
    logic [VALUE_WIDTH-1:0]       res_reg;
    logic [bdq_pkg::STATUS_W-1:0] stat_reg;
    logic [bdq_pkg::DATA_W-1:0]   out_value_reg;
    logic [bdq_pkg::STATUS_W-1:0] out_status_reg;
    logic [bdq_pkg::COUNT_W-1:0]  out_count_reg;

    logic [XW-1:0]                cnt_x;
    logic [XW-1:0]                pos_x;
    logic [XW-1:0]                k_x;
    logic                         is_full;
    logic                         is_empty;
    logic                         pos_lt_count;
    logic                         pos_gt_count;
    logic [bdq_pkg::STATUS_W-1:0] code;
    logic                         ok;
    logic [AW-1:0]                front_dec;
    logic [63:0]                  item_wide;
    logic [63:0]                  res_wide;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [VALUE_WIDTH-1:0]       wr_data;
    logic [AW-1:0]                rd_addr;
    logic [VALUE_WIDTH-1:0]       rd_data;

    // ring index of an offset from the front, offset at most the capacity
    function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] front,
                                                input logic [XW-1:0] offset);
        logic [XW-1:0] sum;
        sum = XW'(front) + offset;
        if (sum >= XW'(CAPACITY))
        begin
            sum = sum - XW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign cnt_x        = XW'(count_reg);
    assign pos_x        = XW'(pos_reg);
    assign k_x          = XW'(k_reg);
    assign is_full      = (cnt_x == XW'(CAPACITY));
    assign is_empty     = (count_reg == '0);
    assign pos_lt_count = (pos_x < cnt_x);
    assign pos_gt_count = (pos_x > cnt_x);
    assign front_dec    = (front_reg == '0) ? AW'(CAPACITY - 1) : front_reg - AW'(1);
    assign item_wide    = 64'($unsigned(item_value));
    assign res_wide     = 64'(res_reg);

    always_comb
    begin
        code = bdq_pkg::ST_OK;
        case (mode_reg)
            bdq_pkg::MODE_PUSH_BACK, bdq_pkg::MODE_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    code = bdq_pkg::ST_FULL;
                end
            end
            bdq_pkg::MODE_POP_FRONT, bdq_pkg::MODE_POP_BACK:
            begin
                if (is_empty)
                begin
                    code = bdq_pkg::ST_EMPTY;
                end
            end
            bdq_pkg::MODE_READ_AT:
            begin
                if (!pos_lt_count)
                begin
                    code = bdq_pkg::ST_RANGE;
                end
            end
            bdq_pkg::MODE_INSERT_AT:
            begin
                if (is_full)
                begin
                    code = bdq_pkg::ST_FULL;
                end
                else if (pos_gt_count)
                begin
                    code = bdq_pkg::ST_RANGE;
                end
            end
            default:
            begin
                code = bdq_pkg::ST_OK;
            end
        endcase
    end

    assign ok = (code == bdq_pkg::ST_OK);

    assign stat.needs_read  = ok && ((mode_reg == bdq_pkg::MODE_POP_FRONT) ||
                                     (mode_reg == bdq_pkg::MODE_POP_BACK) ||
                                     (mode_reg == bdq_pkg::MODE_READ_AT));
    assign stat.needs_shift = ok && (mode_reg == bdq_pkg::MODE_INSERT_AT) && pos_lt_count;
    assign stat.shift_last  = ((k_x - XW'(1)) == pos_x);

    // ram ports and pointer updates
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = val_reg;
        rd_addr    = '0;
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.exec && ok)
        begin
            case (mode_reg)
                bdq_pkg::MODE_PUSH_BACK:
                begin
                    wr_en      = 1'b1;
                    wr_addr    = ring_slot(front_reg, cnt_x);
                    count_next = count_reg + CW'(1);
                end
                bdq_pkg::MODE_PUSH_FRONT:
                begin
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
                bdq_pkg::MODE_POP_FRONT:
                begin
                    rd_addr    = front_reg;
                    front_next = ring_slot(front_reg, XW'(1));
                    count_next = count_reg - CW'(1);
                end
                bdq_pkg::MODE_POP_BACK:
                begin
                    rd_addr    = ring_slot(front_reg, cnt_x - XW'(1));
                    count_next = count_reg - CW'(1);
                end
                bdq_pkg::MODE_READ_AT:
                begin
                    rd_addr = ring_slot(front_reg, pos_x);
                end
                bdq_pkg::MODE_INSERT_AT:
                begin
                    // insert at the count is a plain append
                    if (!pos_lt_count)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ring_slot(front_reg, cnt_x);
                        count_next = count_reg + CW'(1);
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        if (cmd.shift_rd)
        begin
            rd_addr = ring_slot(front_reg, k_x - XW'(1));
        end
        if (cmd.shift_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = ring_slot(front_reg, k_x);
            wr_data = rd_data;
        end
        if (cmd.place)
        begin
            wr_en      = 1'b1;
            wr_addr    = ring_slot(front_reg, pos_x);
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            mode_reg <= mode;
            val_reg  <= item_wide[VALUE_WIDTH-1:0];
            pos_reg  <= position;
        end
        if (cmd.exec)
        begin
            stat_reg <= code;
            res_reg  <= '0;
            k_reg    <= count_reg;
        end
        if (cmd.capture_rd)
        begin
            res_reg <= rd_data;
        end
        if (cmd.shift_wr)
        begin
            k_reg <= k_reg - CW'(1);
        end
        if (cmd.load_out)
        begin
            out_value_reg  <= res_wide[bdq_pkg::DATA_W-1:0];
            out_status_reg <= stat_reg;
            out_count_reg  <= cnt_x[bdq_pkg::COUNT_W-1:0];
        end
    end

    assign result_value = out_value_reg;
    assign status       = out_status_reg;
    assign entry_count  = out_count_reg;

    bdq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> src/bounded_deque_indexed.sv
// top level of the bounded deque with indexed read and insert
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_ctrl, bdq_dpath
//
//   channel  role    fields
//   req      sink    mode[2:0], item_value[31:0] signed, position[4:0]
//   rsp      source  result_value[31:0] signed, status[1:0], entry_count[4:0]
//
// one item at a time; states from acceptance to the next acceptance:
//   push, error or unused mode: exec, finish; pop and read: exec, wait_rd
//   (registered ram read), finish; insert before the back: exec, one ram read and
//   one ram write per shifted entry through the single read and write port, place, finish
// reset clears the front pointer, count, controller state and output valid only; no clearing pass
// a finished result waits in the output register while req stays open;
// a further result waits in its final state until rsp drains
`default_nettype none

module bounded_deque_indexed #(
    parameter int CAPACITY    = bdq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    bdq_req_if.sink  req,
    bdq_rsp_if.source rsp
);

    localparam int OUT_CW = bdq_pkg::COUNT_W;
    localparam logic [OUT_CW-1:0] FULL_COUNT = OUT_CW'(CAPACITY % (2 ** OUT_CW));

    bdq_pkg::bdq_cmd_t  ctrl_cmd;
    bdq_pkg::bdq_stat_t dp_stat;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (dp_stat),
        .cmd       (ctrl_cmd)
    );

    bdq_dpath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl_cmd),
        .stat         (dp_stat),
        .mode         (req.mode),
        .item_value   (req.item_value),
        .position     (req.position),
        .result_value (rsp.result_value),
        .status       (rsp.status),
        .entry_count  (rsp.entry_count)
    );

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ctrl_cmd))
        else $error("more than one datapath command at once");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("new item taken while one is in progress");

    a_rsp_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(ctrl_cmd.load_out))
        else $error("result shown without a load");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == bdq_pkg::ST_FULL)) |-> (rsp.entry_count == FULL_COUNT))
        else $error("full status with a count below capacity");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == bdq_pkg::ST_EMPTY)) |->
            ((rsp.entry_count == '0) && (rsp.result_value == '0)))
        else $error("empty status with entries or a value");

endmodule

`default_nettype wire

>>> tb/bounded_deque_indexed_checker.sv
// checker for the bounded indexed deque: watches request and result channels,
// keeps a shadow deque, and compares every result with its prediction
// depends on bdq_pkg
`timescale 1ns / 1ps

module bounded_deque_indexed_checker #(
    parameter int CAPACITY    = bdq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    input  wire logic                                req_ready,
    input  wire logic [bdq_pkg::MODE_W-1:0]          req_mode,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]   req_item_value,
    input  wire logic [bdq_pkg::POS_W-1:0]           req_position,
    input  wire logic                                rsp_valid,
    input  wire logic                                rsp_ready,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]   rsp_result_value,
    input  wire logic [bdq_pkg::STATUS_W-1:0]        rsp_status,
    input  wire logic [bdq_pkg::COUNT_W-1:0]         rsp_entry_count,
    output int                                       fail_count,
    output int                                       pending_results
);

    typedef struct {
        logic [bdq_pkg::DATA_W-1:0]   value;
        logic [bdq_pkg::STATUS_W-1:0] status;
        logic [bdq_pkg::COUNT_W-1:0]  count;
    } deque_result_t;

    logic [VALUE_WIDTH-1:0] shadow_store [CAPACITY];
    int                     shadow_front;
    int                     shadow_held;
    deque_result_t          expected_results [$];
    int                     mismatches  = 0;
    int                     outstanding = 0;

    assign fail_count      = mismatches;
    assign pending_results = outstanding;

    function automatic int ring_slot(input int offset);
        return (shadow_front + offset) % CAPACITY;
    endfunction

    task automatic predict_request(input logic [bdq_pkg::MODE_W-1:0] mode,
                                   input logic [bdq_pkg::DATA_W-1:0] value,
                                   input logic [bdq_pkg::POS_W-1:0]  pos);
        deque_result_t          res;
        logic [VALUE_WIDTH-1:0] kept;
        int                     k;
        res.value  = '0;
        res.status = bdq_pkg::ST_OK;
        kept       = VALUE_WIDTH'(value);
        case (mode)
            bdq_pkg::MODE_PUSH_BACK:
                if (shadow_held >= CAPACITY)
                    res.status = bdq_pkg::ST_FULL;
                else
                begin
                    shadow_store[ring_slot(shadow_held)] = kept;
                    shadow_held++;
                end
            bdq_pkg::MODE_PUSH_FRONT:
                if (shadow_held >= CAPACITY)
                    res.status = bdq_pkg::ST_FULL;
                else
                begin
                    shadow_front = ring_slot(CAPACITY - 1);
                    shadow_store[shadow_front] = kept;
                    shadow_held++;
                end
            bdq_pkg::MODE_POP_FRONT:
                if (shadow_held == 0)
                    res.status = bdq_pkg::ST_EMPTY;
                else
                begin
                    res.value = bdq_pkg::DATA_W'(shadow_store[shadow_front]);
                    shadow_front = ring_slot(1);
                    shadow_held--;
                end
            bdq_pkg::MODE_POP_BACK:
                if (shadow_held == 0)
                    res.status = bdq_pkg::ST_EMPTY;
                else
                begin
                    res.value = bdq_pkg::DATA_W'(shadow_store[ring_slot(shadow_held - 1)]);
                    shadow_held--;
                end
            bdq_pkg::MODE_READ_AT:
                if (int'(pos) >= shadow_held)
                    res.status = bdq_pkg::ST_RANGE;
                else
                    res.value = bdq_pkg::DATA_W'(shadow_store[ring_slot(int'(pos))]);
            bdq_pkg::MODE_INSERT_AT:
                if (shadow_held >= CAPACITY)
                    res.status = bdq_pkg::ST_FULL;
                else if (int'(pos) > shadow_held)
                    res.status = bdq_pkg::ST_RANGE;
                else
                begin
                    for (k = shadow_held; k > int'(pos); k--)
                        shadow_store[ring_slot(k)] = shadow_store[ring_slot(k - 1)];
                    shadow_store[ring_slot(int'(pos))] = kept;
                    shadow_held++;
                end
            default:
                ;
        endcase
        res.count = bdq_pkg::COUNT_W'(shadow_held);
        expected_results = {expected_results, res};
    endtask

    task automatic check_result();
        deque_result_t exp_res;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: result_value %0d status %0d entry_count %0d",
                   rsp_result_value, rsp_status, rsp_entry_count);
            mismatches++;
        end
        else
        begin
            exp_res = expected_results[0];
            expected_results.delete(0);
            if (rsp_result_value !== exp_res.value)
            begin
                $error("result_value: expected %0d, got %0d",
                       $signed(exp_res.value), rsp_result_value);
                mismatches++;
            end
            if (rsp_status !== exp_res.status)
            begin
                $error("status: expected %0d, got %0d", exp_res.status, rsp_status);
                mismatches++;
            end
            if (rsp_entry_count !== exp_res.count)
            begin
                $error("entry_count: expected %0d, got %0d", exp_res.count, rsp_entry_count);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_front = 0;
            shadow_held  = 0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
                check_result();
            if (req_valid && req_ready)
                predict_request(req_mode, req_item_value, req_position);
            outstanding <= expected_results.size();
        end
    end

endmodule

>>> tb/bounded_deque_indexed_tb.sv
// top of the bounded indexed deque testbench: clock, reset, request stimulus
// with bursts and gaps, result back-pressure, and the final verdict
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bounded_deque_indexed, the checker
`timescale 1ns / 1ps

module bounded_deque_indexed_tb;

    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASE_LEN    = 120;
    localparam int DRAIN_CYCLES = 60;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_results;
    int   burst_left = 0;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_indexed DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bounded_deque_indexed_checker deque_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_ch.valid),
        .req_ready        (req_ch.ready),
        .req_mode         (req_ch.mode),
        .req_item_value   (req_ch.item_value),
        .req_position     (req_ch.position),
        .rsp_valid        (rsp_ch.valid),
        .rsp_ready        (rsp_ch.ready),
        .rsp_result_value (rsp_ch.result_value),
        .rsp_status       (rsp_ch.status),
        .rsp_entry_count  (rsp_ch.entry_count),
        .fail_count       (fail_count),
        .pending_results  (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("bounded_deque_indexed_tb: errors");
        $finish;
    end

    task automatic offer_item(input logic [bdq_pkg::MODE_W-1:0]        mode,
                              input logic signed [bdq_pkg::DATA_W-1:0] value,
                              input logic [bdq_pkg::POS_W-1:0]         pos);
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= mode;
        req_ch.item_value <= value;
        req_ch.position   <= pos;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    function automatic logic signed [bdq_pkg::DATA_W-1:0] pick_item_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [bdq_pkg::POS_W-1:0] pick_position();
        if ($urandom_range(0, 1) == 0)
            return bdq_pkg::POS_W'($urandom_range(0, 4));
        return bdq_pkg::POS_W'($urandom_range(0, bdq_pkg::CAPACITY_DEF));
    endfunction

    // fill, drain and mixed phases keep the count sweeping between empty and full
    function automatic logic [bdq_pkg::MODE_W-1:0] pick_mode(input int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            0:
                if (r < 35)      return bdq_pkg::MODE_PUSH_BACK;
                else if (r < 60) return bdq_pkg::MODE_PUSH_FRONT;
                else if (r < 80) return bdq_pkg::MODE_INSERT_AT;
                else if (r < 90) return bdq_pkg::MODE_READ_AT;
                else if (r < 95) return bdq_pkg::MODE_POP_FRONT;
                else             return bdq_pkg::MODE_POP_BACK;
            1:
                if (r < 10)      return bdq_pkg::MODE_PUSH_BACK;
                else if (r < 15) return bdq_pkg::MODE_PUSH_FRONT;
                else if (r < 20) return bdq_pkg::MODE_INSERT_AT;
                else if (r < 35) return bdq_pkg::MODE_READ_AT;
                else if (r < 70) return bdq_pkg::MODE_POP_FRONT;
                else             return bdq_pkg::MODE_POP_BACK;
            default:
                return bdq_pkg::MODE_W'($urandom_range(0, 5));
        endcase
    endfunction

    initial
    begin
        int i;
        int phase;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= bdq_pkg::MODE_PUSH_BACK;
        req_ch.item_value <= '0;
        req_ch.position   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty store cases
        offer_item(bdq_pkg::MODE_POP_FRONT, 32'sd0, 5'd0);
        offer_item(bdq_pkg::MODE_POP_BACK, 32'sh1234, 5'd3);
        offer_item(bdq_pkg::MODE_READ_AT, 32'sd0, 5'd0);
        offer_item(bdq_pkg::MODE_INSERT_AT, 32'sd5, 5'd1);
        offer_item(bdq_pkg::MODE_INSERT_AT, 32'sd1, 5'd0);
        // extreme values, middle insert and append by insert
        offer_item(bdq_pkg::MODE_PUSH_BACK, 32'sh7fff_ffff, 5'd0);
        offer_item(bdq_pkg::MODE_PUSH_FRONT, 32'sh8000_0000, 5'd31);
        offer_item(bdq_pkg::MODE_PUSH_BACK, -32'sd1, 5'd0);
        offer_item(bdq_pkg::MODE_INSERT_AT, 32'sh5555_5555, 5'd2);
        offer_item(bdq_pkg::MODE_INSERT_AT, 32'shaaaa_aaaa, 5'd5);
        offer_item(bdq_pkg::MODE_READ_AT, 32'sd0, 5'd5);
        offer_item(bdq_pkg::MODE_READ_AT, 32'sd0, 5'd6);
        offer_item(bdq_pkg::MODE_READ_AT, 32'sd0, 5'd16);
        // fill to capacity, then the full cases
        for (i = 0; i < 10; i++)
            offer_item(i[0] ? bdq_pkg::MODE_PUSH_FRONT : bdq_pkg::MODE_PUSH_BACK,
                       32'(i * 32'h0101_0101), 5'd0);
        offer_item(bdq_pkg::MODE_PUSH_BACK, 32'sd9, 5'd0);
        offer_item(bdq_pkg::MODE_INSERT_AT, 32'sd9, 5'd16);
        offer_item(bdq_pkg::MODE_READ_AT, 32'sd0, 5'd15);
        offer_item(bdq_pkg::MODE_POP_BACK, 32'sd0, 5'd0);
        offer_item(bdq_pkg::MODE_POP_FRONT, 32'sd0, 5'd0);

        phase = 0;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_LEN == 0)
                phase = $urandom_range(0, 2);
            offer_item(pick_mode(phase), pick_item_value(), pick_position());
        end
        req_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("bounded_deque_indexed_tb: clean");
        else
            $display("bounded_deque_indexed_tb: errors");
        $finish;
    end

    // receiver: stretches of varying acceptance rate, plus two long hold-offs
    initial
    begin
        int cycles_seen;
        int stretch_left;
        int ready_pct;
        cycles_seen  = 0;
        stretch_left = 0;
        ready_pct    = 100;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycles_seen++;
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(10, 150);
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 80;
                    2:       ready_pct = 50;
                    default: ready_pct = 20;
                endcase
            end
            stretch_left--;
            if (cycles_seen == 2500 || cycles_seen == 9000)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                cycles_seen += 300;
            end
            else
                rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

endmodule

>>> bounded_deque_indexed.f
src/bdq_pkg.sv
src/bdq_req_if.sv
src/bdq_rsp_if.sv
src/bdq_ram.sv
src/bdq_ctrl.sv
src/bdq_dpath.sv
src/bounded_deque_indexed.sv
tb/bounded_deque_indexed_checker.sv
tb/bounded_deque_indexed_tb.sv
